>>> rtl/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg
// Types and codes shared by the order matcher's controller and datapath.
// ----------------------------------------------------------------------------
package lom_pkg;

    localparam int MAX_FILLS = 32;
    localparam int FILL_W    = 6;

    localparam logic [1:0] CMD_NEW    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;
    localparam logic [2:0] ST_MODIFIED  = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic [1:0] QSEL_ZERO  = 2'd0;
    localparam logic [1:0] QSEL_FOUND = 2'd1;
    localparam logic [1:0] QSEL_REM   = 2'd2;

    typedef struct packed {
        logic        side;
        logic [3:0]  client;
        logic [15:0] id;
        logic [31:0] arr_time;
        logic [15:0] qty;
        logic [15:0] price;
    } slot_t;

    typedef struct packed {
        logic [31:0] buy_qty;
        logic [31:0] sell_qty;
        logic [47:0] bought_val;
        logic [47:0] sold_val;
    } acc_t;

    typedef struct packed {
        logic       load;
        logic       scan_clr;
        logic       scan_step;
        logic       scan_best;
        logic       match_init;
        logic       tgt_found;
        logic       cancel_clr;
        logic       pick;
        logic       apply;
        logic       cr_taker;
        logic       cr_rest;
        logic       acc_sel_rest;
        logic       enter;
        logic       set_stat;
        logic [2:0] stat_code;
        logic [1:0] qsel;
        logic       out_fill;
        logic       out_stat;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_cmd;
        logic       scan_done;
        logic       found;
        logic       free_found;
        logic       best_found;
        logic       rem_zero;
        logic       fills_max;
        logic       out_free;
    } sts_t;

endpackage

>>> rtl/lom_ram.sv
// ----------------------------------------------------------------------------
// lom_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> rtl/lom_ctrl.sv
// ----------------------------------------------------------------------------
// lom_ctrl
// Sequencer for the order matcher: id scan, match loop, credit and results.
// ----------------------------------------------------------------------------
module lom_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lom_pkg::sts_t sts,
    output lom_pkg::cmd_t cmd
);
    import lom_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ID_SCAN  = 4'd1;
    localparam logic [3:0] S_ID_DONE  = 4'd2;
    localparam logic [3:0] S_M_CHECK  = 4'd3;
    localparam logic [3:0] S_M_SCAN   = 4'd4;
    localparam logic [3:0] S_M_PICK   = 4'd5;
    localparam logic [3:0] S_APPLY    = 4'd6;
    localparam logic [3:0] S_CR_T     = 4'd7;
    localparam logic [3:0] S_RD_R     = 4'd8;
    localparam logic [3:0] S_CR_R     = 4'd9;
    localparam logic [3:0] S_FILL_OUT = 4'd10;
    localparam logic [3:0] S_ENTER    = 4'd11;
    localparam logic [3:0] S_STAT_RD  = 4'd12;
    localparam logic [3:0] S_STAT_OUT = 4'd13;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_ID_SCAN;
                end
            end
            S_ID_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_ID_DONE;
                end
            end
            S_ID_DONE: begin
                case (sts.in_cmd)
                    CMD_NEW: begin
                        if (sts.found) begin
                            cmd.set_stat  = 1'b1;
                            cmd.stat_code = ST_DUPLICATE;
                            cmd.qsel      = QSEL_ZERO;
                            state_next    = S_STAT_RD;
                        end else if (!sts.free_found) begin
                            cmd.set_stat  = 1'b1;
                            cmd.stat_code = ST_FULL;
                            cmd.qsel      = QSEL_ZERO;
                            state_next    = S_STAT_RD;
                        end else begin
                            cmd.match_init = 1'b1;
                            state_next     = S_M_CHECK;
                        end
                    end
                    CMD_CANCEL, CMD_MODIFY: begin
                        if (!sts.found) begin
                            cmd.set_stat  = 1'b1;
                            cmd.stat_code = ST_NOT_FOUND;
                            cmd.qsel      = QSEL_ZERO;
                            state_next    = S_STAT_RD;
                        end else if (sts.in_cmd == CMD_CANCEL) begin
                            cmd.cancel_clr = 1'b1;
                            cmd.set_stat   = 1'b1;
                            cmd.stat_code  = ST_CANCELLED;
                            cmd.qsel       = QSEL_FOUND;
                            state_next     = S_STAT_RD;
                        end else begin
                            cmd.cancel_clr = 1'b1;
                            cmd.match_init = 1'b1;
                            cmd.tgt_found  = 1'b1;
                            state_next     = S_M_CHECK;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_M_CHECK: begin
                if (sts.rem_zero || sts.fills_max) begin
                    state_next = S_ENTER;
                end else begin
                    cmd.scan_clr  = 1'b1;
                    cmd.scan_best = 1'b1;
                    state_next    = S_M_SCAN;
                end
            end
            S_M_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_M_PICK;
                end
            end
            S_M_PICK: begin
                if (!sts.best_found) begin
                    state_next = S_ENTER;
                end else begin
                    cmd.pick   = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = S_CR_T;
            end
            S_CR_T: begin
                cmd.cr_taker = 1'b1;
                state_next   = S_RD_R;
            end
            S_RD_R: begin
                cmd.acc_sel_rest = 1'b1;
                state_next       = S_CR_R;
            end
            S_CR_R: begin
                cmd.acc_sel_rest = 1'b1;
                cmd.cr_rest      = 1'b1;
                state_next       = S_FILL_OUT;
            end
            S_FILL_OUT: begin
                if (sts.out_free) begin
                    cmd.out_fill = 1'b1;
                    state_next   = S_M_CHECK;
                end
            end
            S_ENTER: begin
                cmd.enter     = 1'b1;
                cmd.set_stat  = 1'b1;
                cmd.stat_code = (sts.in_cmd == CMD_NEW) ? ST_ACCEPTED : ST_MODIFIED;
                cmd.qsel      = QSEL_REM;
                state_next    = S_STAT_RD;
            end
            S_STAT_RD: begin
                state_next = S_STAT_OUT;
            end
            S_STAT_OUT: begin
                if (sts.out_free) begin
                    cmd.out_stat = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/lom_dp.sv
// ----------------------------------------------------------------------------
// lom_dp
// Datapath: order slot store, slot scans, client accounts and result register.
// ----------------------------------------------------------------------------
module lom_dp #(
    parameter int ORDER_SLOTS  = 32,
    parameter int CLIENT_COUNT = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [87:0]    s_tdata,
    input  logic [1:0]     s_tuser,
    input  lom_pkg::cmd_t  cmd,
    output lom_pkg::sts_t  sts,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [135:0]   m_tdata,
    output logic           m_tuser,
    output logic           m_tlast
);
    import lom_pkg::*;

    localparam int SW = $clog2(ORDER_SLOTS);
    localparam int CW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
    localparam int SLOT_BITS = $bits(slot_t);
    localparam int ACC_BITS  = $bits(acc_t);

    function automatic logic [CW-1:0] cidx(input logic [3:0] c);
        logic [CW-1:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (c == i[3:0]) begin
                r = CW'(i % CLIENT_COUNT);
            end
        end
        return r;
    endfunction

    // latched command
    logic [1:0]  in_cmd_reg;
    logic [15:0] in_id_reg, in_price_reg, in_amount_reg;
    logic [3:0]  in_client_reg;
    logic        in_side_reg;
    logic [31:0] in_time_reg;

    // scan
    logic [SW:0]   cnt_reg;
    logic          pend_reg;
    logic [SW-1:0] pidx_reg;
    logic          best_mode_reg;
    logic          vld_reg  [ORDER_SLOTS];
    logic          book_reg [ORDER_SLOTS];

    logic          found_reg, free_reg;
    logic [SW-1:0] fidx_reg, free_idx_reg;
    logic [15:0]   fqty_reg;

    logic          bfound_reg;
    logic [SW-1:0] bidx_reg;
    slot_t         best_reg;

    // match
    logic [SW-1:0]     tgt_reg;
    logic [15:0]       rem_reg, fill_reg;
    logic [FILL_W-1:0] fills_reg;
    logic [31:0]       prod_reg;
    acc_t              nacc_reg;

    // status
    logic [2:0]  st_code_reg;
    logic [15:0] st_qty_reg;

    // results
    logic         out_vld_reg, out_kind_reg, out_last_reg;
    logic [135:0] out_data_reg;

    // memories
    logic          slot_we;
    logic [SW-1:0] slot_waddr, slot_raddr;
    slot_t         slot_wdata, rd;
    logic [SLOT_BITS-1:0] slot_rdata;

    logic          acc_we;
    logic [CW-1:0] acc_waddr, acc_raddr, acc_raddr_reg;
    acc_t          acc_wdata, acc_eff;
    logic [ACC_BITS-1:0] acc_rdata;

    logic eligible, better, id_hit, credit_sell;
    logic [CW-1:0] in_cidx, rest_cidx;

    lom_ram #(.WIDTH(SLOT_BITS), .DEPTH(ORDER_SLOTS), .AW(SW)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    lom_ram #(.WIDTH(ACC_BITS), .DEPTH(CLIENT_COUNT), .AW(CW)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    logic acc_vld_reg [CLIENT_COUNT];

    assign in_cidx    = cidx(in_client_reg);
    assign rest_cidx  = cidx(best_reg.client);
    assign slot_raddr = cnt_reg[SW-1:0];
    assign acc_raddr  = cmd.acc_sel_rest ? rest_cidx : in_cidx;
    assign rd         = slot_t'(slot_rdata);
    assign acc_eff    = acc_vld_reg[acc_raddr_reg] ? acc_t'(acc_rdata) : '0;

    always_comb begin
        eligible = vld_reg[pidx_reg] && book_reg[pidx_reg] && (rd.side != in_side_reg)
                && (in_side_reg ? (rd.price >= in_price_reg) : (rd.price <= in_price_reg));
        if (rd.price != best_reg.price) begin
            better = in_side_reg ? (rd.price > best_reg.price) : (rd.price < best_reg.price);
        end else if (rd.arr_time != best_reg.arr_time) begin
            better = rd.arr_time < best_reg.arr_time;
        end else begin
            better = rd.id < best_reg.id;
        end
        id_hit = vld_reg[pidx_reg] && (rd.id == in_id_reg);
    end

    // slot writes
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = bidx_reg;
        slot_wdata = best_reg;
        slot_wdata.qty = best_reg.qty - fill_reg;
        if (cmd.apply) begin
            slot_we = 1'b1;
        end else if (cmd.enter) begin
            slot_we    = 1'b1;
            slot_waddr = tgt_reg;
            slot_wdata.side     = in_side_reg;
            slot_wdata.client   = in_client_reg;
            slot_wdata.id       = in_id_reg;
            slot_wdata.arr_time = in_time_reg;
            slot_wdata.qty      = rem_reg;
            slot_wdata.price    = in_price_reg;
        end
    end

    // account updates
    always_comb begin
        acc_we      = cmd.cr_taker || cmd.cr_rest;
        acc_waddr   = cmd.cr_rest ? rest_cidx : in_cidx;
        credit_sell = cmd.cr_rest ? !in_side_reg : in_side_reg;
        acc_wdata   = acc_eff;
        if (credit_sell) begin
            acc_wdata.sell_qty = acc_eff.sell_qty + 32'(fill_reg);
            acc_wdata.sold_val = acc_eff.sold_val + 48'(prod_reg);
        end else begin
            acc_wdata.buy_qty    = acc_eff.buy_qty + 32'(fill_reg);
            acc_wdata.bought_val = acc_eff.bought_val + 48'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CLIENT_COUNT; i++) begin
                acc_vld_reg[i] <= 1'b0;
            end
        end else if (acc_we) begin
            acc_vld_reg[acc_waddr] <= 1'b1;
        end
    end

    // slot flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ORDER_SLOTS; i++) begin
                vld_reg[i]  <= 1'b0;
                book_reg[i] <= 1'b0;
            end
        end else if (cmd.cancel_clr) begin
            vld_reg[fidx_reg] <= 1'b0;
        end else if (cmd.apply) begin
            if (best_reg.qty == fill_reg) begin
                vld_reg[bidx_reg]  <= 1'b0;
                book_reg[bidx_reg] <= 1'b0;
            end
        end else if (cmd.enter) begin
            vld_reg[tgt_reg]  <= 1'b1;
            book_reg[tgt_reg] <= (rem_reg != 16'd0);
        end
    end

    // scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else if (cmd.scan_clr) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            pend_reg <= (cnt_reg != (SW+1)'(ORDER_SLOTS));
            if (cnt_reg != (SW+1)'(ORDER_SLOTS)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg      <= cnt_reg[SW-1:0];
        acc_raddr_reg <= acc_raddr;
        if (cmd.load) begin
            in_cmd_reg    <= s_tuser;
            in_id_reg     <= s_tdata[15:0];
            in_client_reg <= s_tdata[19:16];
            in_side_reg   <= s_tdata[20];
            in_price_reg  <= s_tdata[36:21];
            in_amount_reg <= s_tdata[52:37];
            in_time_reg   <= s_tdata[84:53];
        end
        if (cmd.scan_clr) begin
            best_mode_reg <= cmd.scan_best;
            bfound_reg    <= 1'b0;
            if (!cmd.scan_best) begin
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
        end else if (cmd.scan_step && pend_reg) begin
            if (best_mode_reg) begin
                if (eligible && (!bfound_reg || better)) begin
                    bfound_reg <= 1'b1;
                    bidx_reg   <= pidx_reg;
                    best_reg   <= rd;
                end
            end else begin
                if (!vld_reg[pidx_reg] && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= pidx_reg;
                end
                if (id_hit && !found_reg) begin
                    found_reg <= 1'b1;
                    fidx_reg  <= pidx_reg;
                    fqty_reg  <= rd.qty;
                end
            end
        end
        if (cmd.match_init) begin
            tgt_reg   <= cmd.tgt_found ? fidx_reg : free_idx_reg;
            rem_reg   <= in_amount_reg;
            fills_reg <= '0;
        end
        if (cmd.pick) begin
            fill_reg <= (best_reg.qty < rem_reg) ? best_reg.qty : rem_reg;
        end
        if (cmd.apply) begin
            prod_reg  <= fill_reg * best_reg.price;
            rem_reg   <= rem_reg - fill_reg;
            fills_reg <= fills_reg + 1'b1;
        end
        if (cmd.cr_rest) begin
            nacc_reg <= acc_wdata;
        end
        if (cmd.set_stat) begin
            st_code_reg <= cmd.stat_code;
            case (cmd.qsel)
                QSEL_FOUND: st_qty_reg <= fqty_reg;
                QSEL_REM:   st_qty_reg <= rem_reg;
                default:    st_qty_reg <= 16'd0;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.out_fill || cmd.out_stat) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_fill) begin
            out_kind_reg          <= 1'b0;
            out_last_reg          <= 1'b0;
            out_data_reg[2:0]     <= ST_ACCEPTED;
            out_data_reg[18:3]    <= best_reg.id;
            out_data_reg[22:19]   <= best_reg.client;
            out_data_reg[38:23]   <= fill_reg;
            out_data_reg[54:39]   <= best_reg.price;
            out_data_reg[86:55]   <= nacc_reg.buy_qty - nacc_reg.sell_qty;
            out_data_reg[134:87]  <= nacc_reg.sold_val - nacc_reg.bought_val;
            out_data_reg[135]     <= 1'b0;
        end else if (cmd.out_stat) begin
            out_kind_reg          <= 1'b1;
            out_last_reg          <= 1'b1;
            out_data_reg[2:0]     <= st_code_reg;
            out_data_reg[18:3]    <= in_id_reg;
            out_data_reg[22:19]   <= in_client_reg;
            out_data_reg[38:23]   <= st_qty_reg;
            out_data_reg[54:39]   <= 16'd0;
            out_data_reg[86:55]   <= acc_eff.buy_qty - acc_eff.sell_qty;
            out_data_reg[134:87]  <= acc_eff.sold_val - acc_eff.bought_val;
            out_data_reg[135]     <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        sts            = '0;
        sts.in_cmd     = in_cmd_reg;
        sts.scan_done  = (cnt_reg == (SW+1)'(ORDER_SLOTS)) && !pend_reg;
        sts.found      = found_reg;
        sts.free_found = free_reg;
        sts.best_found = bfound_reg;
        sts.rem_zero   = (rem_reg == 16'd0);
        sts.fills_max  = (fills_reg == FILL_W'(MAX_FILLS));
        sts.out_free   = !out_vld_reg || m_tready;
    end

endmodule

>>> rtl/limit_order_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_matcher
// Price-time priority limit order book: new, cancel and modify commands.
// ----------------------------------------------------------------------------
//  channel  | signals                          | contents
//  ---------+----------------------------------+------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser| one command per transfer
//  result   | m_tvalid m_tready m_tdata m_tuser| fills, then status (m_tlast)
//
// One command at a time. Each command is accepted and its id scanned; each fill
// adds a best-order scan, then update, account credit and result; the loop
// closes when the remaining amount is zero, the fill limit is reached or a
// best-order scan finds nothing; entry and status follow.
// aresetn is synchronous: slots and client accounts read as empty after it.
// A stalled result register holds the sequencer until the transfer completes.
module limit_order_matcher #(
    parameter int ORDER_SLOTS  = 32,
    parameter int CLIENT_COUNT = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ord_id[15:0] cli_id[19:16] side[20] limit_price[36:21]
    // amount[52:37] arrival_time[84:53]
    input  logic [87:0]  s_tdata,
    // command[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0] ref_id[18:3] ref_client[22:19] qty_out[38:23]
    // exec_price[54:39] net_pos[86:55] profit[134:87]
    output logic [135:0] m_tdata,
    // kind[0]
    output logic         m_tuser,
    output logic         m_tlast
);
    import lom_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lom_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lom_dp #(
        .ORDER_SLOTS  (ORDER_SLOTS),
        .CLIENT_COUNT (CLIENT_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
